// ===== hw/rtl/nrm_pkg.sv =====
// Package of the L2 vector normaliser: sizes, payload and command types, state codes.
// Depends on nothing; every other file of the block uses it by scoped names.
package nrm_pkg;

    localparam int VECTOR_LENGTH = 512;
    localparam int LANE_COUNT = 8;
    localparam int FIELD_LANES = 8;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W = 40;
    localparam int GROUP_SPAN = (VECTOR_LENGTH + LANE_COUNT - 1) / LANE_COUNT;
    localparam int GROUP_CAP = (GROUP_SPAN < 64) ? GROUP_SPAN : 64;
    localparam int ROW_W = (GROUP_CAP > 1) ? $clog2(GROUP_CAP) : 1;
    localparam int COUNT_W = $clog2(GROUP_CAP + 1);
    localparam int SQ_W = 2 * SAMPLE_W - 1;
    localparam int QUOT_W = 31;
    localparam int DIV_CNT_W = 5;
    localparam int ROOT_STEPS = 16;
    localparam int ROOT_CNT_W = 4;
    localparam int ROOT_W = 32;
    localparam int ONE_Q14 = 16384;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef logic [FIELD_LANES-1:0][SAMPLE_W-1:0] row_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_0;
        logic signed [SAMPLE_W-1:0] sample_1;
        logic signed [SAMPLE_W-1:0] sample_2;
        logic signed [SAMPLE_W-1:0] sample_3;
        logic signed [SAMPLE_W-1:0] sample_4;
        logic signed [SAMPLE_W-1:0] sample_5;
        logic signed [SAMPLE_W-1:0] sample_6;
        logic signed [SAMPLE_W-1:0] sample_7;
        logic                       vector_end;
    } vec_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] unit_0;
        logic signed [SAMPLE_W-1:0] unit_1;
        logic signed [SAMPLE_W-1:0] unit_2;
        logic signed [SAMPLE_W-1:0] unit_3;
        logic signed [SAMPLE_W-1:0] unit_4;
        logic signed [SAMPLE_W-1:0] unit_5;
        logic signed [SAMPLE_W-1:0] unit_6;
        logic signed [SAMPLE_W-1:0] unit_7;
        logic                       group_last;
    } norm_item_t;

    typedef struct packed {
        logic               load;
        logic               finish;
        logic [ROW_W-1:0]   row;
        row_t               data;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        F_IDLE   = 3'b001,
        F_SQUARE = 3'b010,
        F_PUSH   = 3'b100
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_READ  = 4'b0010,
        B_START = 4'b0100,
        B_RUN   = 4'b1000
    } back_state_t;

    typedef enum logic [3:0] {
        L_IDLE   = 4'b0001,
        L_SQUARE = 4'b0010,
        L_DIVIDE = 4'b0100,
        L_ROOT   = 4'b1000
    } lane_state_t;

endpackage

// ===== hw/rtl/nrm_vec_if.sv =====
// Channel of input groups: valid, ready and one group of raw samples.
// Depends on nrm_pkg.
interface nrm_vec_if;
    logic              valid;
    logic              ready;
    nrm_pkg::vec_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/nrm_norm_if.sv =====
// Channel of result groups: valid, ready and one group of normalised samples.
// Depends on nrm_pkg.
interface nrm_norm_if;
    logic               valid;
    logic               ready;
    nrm_pkg::norm_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/nrm_front.sv =====
// Front end: accepts input groups, masks unused lanes, squares and sums the samples.
// Depends on nrm_pkg and nrm_vec_if; issues commands to the queue.
module nrm_front (
    input  logic          clk,
    input  logic          rst_n,
    nrm_vec_if.sink       vec,
    output nrm_pkg::cmd_t cmd,
    output logic          cmd_push,
    input  logic          cmd_full
);

    nrm_pkg::front_state_t state_reg, state_next;
    nrm_pkg::row_t row_reg;
    nrm_pkg::row_t row_in;
    logic store_reg;
    logic end_reg;
    logic [nrm_pkg::COUNT_W-1:0] count_reg;
    logic [nrm_pkg::SUM_W-1:0] sum_reg;
    logic [nrm_pkg::SUM_W-1:0] sum_next;
    logic [nrm_pkg::SQ_W-1:0] sq_reg [nrm_pkg::FIELD_LANES];
    logic [nrm_pkg::SAMPLE_W-1:0] mag [nrm_pkg::FIELD_LANES];
    logic accept;
    logic room;

    assign vec.ready = (state_reg == nrm_pkg::F_IDLE);
    assign accept = vec.valid && vec.ready;
    assign room = (int'(count_reg) < nrm_pkg::GROUP_CAP);

    always_comb
    begin
        row_in = {vec.data.sample_7, vec.data.sample_6, vec.data.sample_5, vec.data.sample_4,
                  vec.data.sample_3, vec.data.sample_2, vec.data.sample_1, vec.data.sample_0};
        for (int l = 0; l < nrm_pkg::FIELD_LANES; l++)
        begin
            if (!(l < nrm_pkg::LANE_COUNT
                  && int'(count_reg) * nrm_pkg::LANE_COUNT + l < nrm_pkg::VECTOR_LENGTH
                  && room))
            begin
                row_in[l] = '0;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < nrm_pkg::FIELD_LANES; l++)
        begin
            mag[l] = row_reg[l][nrm_pkg::SAMPLE_W-1] ? (~row_reg[l] + 1'b1) : row_reg[l];
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        for (int l = 0; l < nrm_pkg::FIELD_LANES; l++)
        begin
            sum_next = sum_next + nrm_pkg::SUM_W'(sq_reg[l]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nrm_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    state_next = nrm_pkg::F_SQUARE;
                end
            end
            nrm_pkg::F_SQUARE:
            begin
                state_next = nrm_pkg::F_PUSH;
            end
            nrm_pkg::F_PUSH:
            begin
                if (!cmd_full)
                begin
                    state_next = nrm_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = nrm_pkg::F_IDLE;
            end
        endcase
    end

    assign cmd_push = (state_reg == nrm_pkg::F_PUSH) && !cmd_full && (store_reg || end_reg);
    assign cmd.load = store_reg;
    assign cmd.finish = end_reg;
    assign cmd.row = count_reg[nrm_pkg::ROW_W-1:0];
    assign cmd.data = row_reg;
    assign cmd.sum = sum_next;
    assign cmd.count = count_reg + nrm_pkg::COUNT_W'(store_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nrm_pkg::F_IDLE;
            count_reg <= '0;
            sum_reg <= '0;
            store_reg <= 1'b0;
            end_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                store_reg <= room;
                end_reg <= vec.data.vector_end;
            end
            if (state_reg == nrm_pkg::F_PUSH && !cmd_full)
            begin
                if (end_reg)
                begin
                    sum_reg <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    count_reg <= count_reg + nrm_pkg::COUNT_W'(store_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= row_in;
        end
        if (state_reg == nrm_pkg::F_SQUARE)
        begin
            for (int l = 0; l < nrm_pkg::FIELD_LANES; l++)
            begin
                sq_reg[l] <= nrm_pkg::SQ_W'(mag[l]) * nrm_pkg::SQ_W'(mag[l]);
            end
        end
    end

endmodule

// ===== hw/rtl/nrm_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on nrm_pkg.
module nrm_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  nrm_pkg::cmd_t          push_data,
    input  logic                   pop,
    output nrm_pkg::cmd_t          pop_data,
    output nrm_pkg::queue_status_t status
);

    nrm_pkg::cmd_t entry_reg [nrm_pkg::QUEUE_DEPTH];
    logic [nrm_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [nrm_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [nrm_pkg::QPTR_W:0] fill_reg;

    assign status.full = (int'(fill_reg) == nrm_pkg::QUEUE_DEPTH);
    assign status.empty = (fill_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/nrm_lane.sv =====
// One lane of the back end: squares a sample, divides by the sum a bit a cycle,
// then takes the integer square root two bits a cycle. Depends on nrm_pkg.
module nrm_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [nrm_pkg::SAMPLE_W-1:0] raw,
    input  logic [nrm_pkg::SUM_W-1:0]    sum,
    output logic                         idle,
    output logic [nrm_pkg::SAMPLE_W-1:0] result
);

    nrm_pkg::lane_state_t state_reg;
    logic neg_reg;
    logic zero_reg;
    logic first_bit_reg;
    logic [nrm_pkg::SAMPLE_W-1:0] mag_reg;
    logic [nrm_pkg::SUM_W-1:0] rem_reg;
    logic [nrm_pkg::QUOT_W-1:0] quot_reg;
    logic [nrm_pkg::QUOT_W-1:0] val_reg;
    logic [nrm_pkg::ROOT_W-1:0] root_reg;
    logic [nrm_pkg::DIV_CNT_W-1:0] div_step_reg;
    logic [nrm_pkg::ROOT_CNT_W-1:0] root_step_reg;
    logic [nrm_pkg::SAMPLE_W-1:0] result_reg;

    logic [nrm_pkg::SQ_W-1:0] sq;
    logic [nrm_pkg::SUM_W:0] trial;
    logic q_bit;
    logic [nrm_pkg::QUOT_W-1:0] quot_next;
    logic [nrm_pkg::ROOT_W-1:0] bit_w;
    logic [nrm_pkg::ROOT_W-1:0] tsum;
    logic take;
    logic [nrm_pkg::ROOT_W-1:0] root_next;
    logic [nrm_pkg::SAMPLE_W:0] n_round;
    logic [nrm_pkg::SAMPLE_W-1:0] n_sat;
    logic [nrm_pkg::SAMPLE_W-1:0] final_val;

    assign idle = (state_reg == nrm_pkg::L_IDLE);
    assign result = result_reg;

    always_comb
    begin
        sq = nrm_pkg::SQ_W'(mag_reg) * nrm_pkg::SQ_W'(mag_reg);
        trial = {rem_reg, (div_step_reg == '0) ? first_bit_reg : 1'b0};
        q_bit = (trial >= {1'b0, sum});
        quot_next = {quot_reg[nrm_pkg::QUOT_W-2:0], q_bit};
        bit_w = nrm_pkg::ROOT_W'(1) << ((nrm_pkg::QUOT_W - 1) - 2 * int'(root_step_reg));
        tsum = root_reg + bit_w;
        take = (nrm_pkg::ROOT_W'(val_reg) >= tsum);
        root_next = take ? ((root_reg >> 1) + bit_w) : (root_reg >> 1);
        n_round = (nrm_pkg::SAMPLE_W + 1)'(
                  ((nrm_pkg::SAMPLE_W + 2)'(root_next[nrm_pkg::SAMPLE_W:0]) + 1'b1) >> 1);
        n_sat = (int'(n_round) > nrm_pkg::ONE_Q14) ? nrm_pkg::SAMPLE_W'(nrm_pkg::ONE_Q14)
                                                   : n_round[nrm_pkg::SAMPLE_W-1:0];
        if (zero_reg)
        begin
            final_val = '0;
        end
        else if (neg_reg)
        begin
            final_val = ~n_sat + 1'b1;
        end
        else
        begin
            final_val = n_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nrm_pkg::L_IDLE;
            div_step_reg <= '0;
            root_step_reg <= '0;
        end
        else
        begin
            case (state_reg)
                nrm_pkg::L_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= nrm_pkg::L_SQUARE;
                    end
                end
                nrm_pkg::L_SQUARE:
                begin
                    div_step_reg <= '0;
                    state_reg <= nrm_pkg::L_DIVIDE;
                end
                nrm_pkg::L_DIVIDE:
                begin
                    div_step_reg <= div_step_reg + 1'b1;
                    if (int'(div_step_reg) == nrm_pkg::QUOT_W - 1)
                    begin
                        root_step_reg <= '0;
                        state_reg <= nrm_pkg::L_ROOT;
                    end
                end
                nrm_pkg::L_ROOT:
                begin
                    root_step_reg <= root_step_reg + 1'b1;
                    if (int'(root_step_reg) == nrm_pkg::ROOT_STEPS - 1)
                    begin
                        state_reg <= nrm_pkg::L_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= nrm_pkg::L_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            nrm_pkg::L_IDLE:
            begin
                if (start)
                begin
                    neg_reg <= raw[nrm_pkg::SAMPLE_W-1];
                    mag_reg <= raw[nrm_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;
                    zero_reg <= (raw == '0) || (sum == '0);
                end
            end
            nrm_pkg::L_SQUARE:
            begin
                rem_reg <= nrm_pkg::SUM_W'(sq >> 1);
                first_bit_reg <= sq[0];
                quot_reg <= '0;
            end
            nrm_pkg::L_DIVIDE:
            begin
                rem_reg <= q_bit ? nrm_pkg::SUM_W'(trial - {1'b0, sum})
                                 : trial[nrm_pkg::SUM_W-1:0];
                quot_reg <= quot_next;
                if (int'(div_step_reg) == nrm_pkg::QUOT_W - 1)
                begin
                    val_reg <= quot_next;
                    root_reg <= '0;
                end
            end
            nrm_pkg::L_ROOT:
            begin
                if (take)
                begin
                    val_reg <= nrm_pkg::QUOT_W'(nrm_pkg::ROOT_W'(val_reg) - tsum);
                end
                root_reg <= root_next;
                if (int'(root_step_reg) == nrm_pkg::ROOT_STEPS - 1)
                begin
                    result_reg <= final_val;
                end
            end
            default:
            begin
                result_reg <= result_reg;
            end
        endcase
    end

endmodule

// ===== hw/rtl/nrm_back.sv =====
// Back end: holds the sample store, runs the output pass through the lane units
// and drives the output register. Depends on nrm_pkg, nrm_norm_if and nrm_lane.
module nrm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  nrm_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    nrm_norm_if.source    norm
);

    nrm_pkg::back_state_t state_reg;
    nrm_pkg::row_t store_mem [nrm_pkg::GROUP_CAP];
    nrm_pkg::row_t rd_row_reg;
    nrm_pkg::row_t res;
    logic [nrm_pkg::SUM_W-1:0] sum_reg;
    logic [nrm_pkg::COUNT_W-1:0] total_reg;
    logic [nrm_pkg::COUNT_W-1:0] g_reg;
    logic [nrm_pkg::FIELD_LANES-1:0] lane_idle;
    logic lanes_idle;
    logic lane_start;
    logic emit;
    logic last;
    nrm_pkg::norm_item_t out_reg;
    logic out_valid_reg;

    assign cmd_pop = (state_reg == nrm_pkg::B_IDLE) && cmd_valid;
    assign lane_start = (state_reg == nrm_pkg::B_START);
    assign lanes_idle = &lane_idle;
    assign emit = (state_reg == nrm_pkg::B_RUN) && lanes_idle && !out_valid_reg;
    assign last = (g_reg == nrm_pkg::COUNT_W'(total_reg - 1'b1));
    assign norm.valid = out_valid_reg;
    assign norm.data = out_reg;

    for (genvar l = 0; l < nrm_pkg::FIELD_LANES; l++)
    begin : g_lane
        nrm_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (lane_start),
            .raw    (rd_row_reg[l]),
            .sum    (sum_reg),
            .idle   (lane_idle[l]),
            .result (res[l])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nrm_pkg::B_IDLE;
            total_reg <= '0;
            g_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (norm.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                nrm_pkg::B_IDLE:
                begin
                    if (cmd_pop && cmd.finish && cmd.count != '0)
                    begin
                        total_reg <= cmd.count;
                        g_reg <= '0;
                        state_reg <= nrm_pkg::B_READ;
                    end
                end
                nrm_pkg::B_READ:
                begin
                    state_reg <= nrm_pkg::B_START;
                end
                nrm_pkg::B_START:
                begin
                    state_reg <= nrm_pkg::B_RUN;
                end
                nrm_pkg::B_RUN:
                begin
                    if (emit)
                    begin
                        g_reg <= g_reg + 1'b1;
                        state_reg <= last ? nrm_pkg::B_IDLE : nrm_pkg::B_READ;
                    end
                end
                default:
                begin
                    state_reg <= nrm_pkg::B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.load)
        begin
            store_mem[cmd.row] <= cmd.data;
        end
        if (cmd_pop && cmd.finish)
        begin
            sum_reg <= cmd.sum;
        end
        if (state_reg == nrm_pkg::B_READ)
        begin
            rd_row_reg <= store_mem[g_reg[nrm_pkg::ROW_W-1:0]];
        end
        if (emit)
        begin
            out_reg <= {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], last};
        end
    end

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("Command taken from an empty queue.");
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nrm_pkg::B_READ |-> g_reg < total_reg)
        else $error("Output pass reads beyond the loaded groups.");
    a_lanes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        lane_start |=> !lanes_idle)
        else $error("Lane units did not start.");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        lane_start |-> lanes_idle)
        else $error("Lane units started while busy.");
`endif

endmodule

// ===== hw/rtl/l2_vector_normalizer_top.sv =====
// L2 vector normaliser: a group of eight Q4.11 samples is loaded, by the accept,
// square and accumulate steps of the front end, into a 64-row store, while the
// running sum of squares builds up. The group marked vector_end starts the output
// pass: each stored group goes through eight serial lane units, one division step
// a cycle for each of the 31 quotient bits and one root step a cycle for each of
// the 16 root bits, giving one Q1.14 result group; the groups of a vector go through
// the lanes one after another, and loading of the next vector continues until the
// two-entry command queue fills. An all-zero vector gives all-zero results.
// Depends on nrm_pkg, nrm_vec_if, nrm_norm_if, nrm_front, nrm_queue and nrm_back.
module l2_vector_normalizer_top (
    input  logic       clk,
    input  logic       rst_n,
    nrm_vec_if.sink    vec,
    nrm_norm_if.source norm
);

    nrm_pkg::cmd_t push_cmd;
    nrm_pkg::cmd_t pop_cmd;
    nrm_pkg::queue_status_t q_status;
    logic push;
    logic pop;

    nrm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .vec      (vec),
        .cmd      (push_cmd),
        .cmd_push (push),
        .cmd_full (q_status.full)
    );

    nrm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .status    (q_status)
    );

    nrm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (pop_cmd),
        .cmd_valid (!q_status.empty),
        .cmd_pop   (pop),
        .norm      (norm)
    );

endmodule
